### hw/rtl/pdf_pkg.sv
`default_nettype none

package pdf_pkg;

    localparam int WORD_FIELD_W = 64;
    localparam int RF_DEPTH     = 15;
    localparam int RF_IDX_W     = 4;

    typedef logic [3:0] t_reg_id;
    typedef logic [3:0] t_icode;

    localparam t_reg_id REG_SP   = 4'd4;
    localparam t_reg_id REG_NONE = 4'd15;

    localparam t_icode IC_RRMOVQ = 4'd2;
    localparam t_icode IC_IRMOVQ = 4'd3;
    localparam t_icode IC_RMMOVQ = 4'd4;
    localparam t_icode IC_MRMOVQ = 4'd5;
    localparam t_icode IC_OPQ    = 4'd6;
    localparam t_icode IC_JXX    = 4'd7;
    localparam t_icode IC_CALL   = 4'd8;
    localparam t_icode IC_RET    = 4'd9;
    localparam t_icode IC_PUSHQ  = 4'd10;
    localparam t_icode IC_POPQ   = 4'd11;

    typedef struct packed {
        logic [18:0]             instr_header;
        logic [WORD_FIELD_W-1:0] const_word;
        logic [WORD_FIELD_W-1:0] next_pc;
        logic [28:0]             hazard_tags;
        logic [WORD_FIELD_W-1:0] exec_value;
        logic [WORD_FIELD_W-1:0] mem_load_value;
        logic [WORD_FIELD_W-1:0] mem_alu_value;
        logic [WORD_FIELD_W-1:0] wb_load_value;
        logic [WORD_FIELD_W-1:0] wb_alu_value;
    } t_in_req;

    typedef struct packed {
        logic [2:0]              out_stat;
        logic [3:0]              out_icode;
        logic [3:0]              out_ifun;
        logic [WORD_FIELD_W-1:0] out_valc;
        logic [WORD_FIELD_W-1:0] operand_a;
        logic [WORD_FIELD_W-1:0] operand_b;
        logic [3:0]              dest_e;
        logic [3:0]              dest_m;
        logic [3:0]              source_a;
        logic [3:0]              source_b;
        logic                    insert_bubble;
    } t_out_req;

    // same bit layout as hazard_tags
    typedef struct packed {
        t_reg_id e_dste;
        t_reg_id m_dstm;
        t_reg_id m_dste;
        t_reg_id w_dstm;
        t_reg_id w_dste;
        t_icode  e_icode;
        t_reg_id e_dstm;
        logic    e_cnd;
    } t_hazard;

    typedef struct packed {
        t_reg_id src_a;
        t_reg_id src_b;
        t_reg_id dst_e;
        t_reg_id dst_m;
    } t_dec;

    function automatic t_dec pick_regs(input t_icode ic, input t_reg_id ra, input t_reg_id rb);
        t_dec d;
        d = '{src_a: REG_NONE, src_b: REG_NONE, dst_e: REG_NONE, dst_m: REG_NONE};
        case (ic)
            IC_RRMOVQ: begin
                d.src_a = ra;
                d.dst_e = rb;
            end
            IC_IRMOVQ: begin
                d.dst_e = rb;
            end
            IC_RMMOVQ: begin
                d.src_a = ra;
                d.src_b = rb;
            end
            IC_MRMOVQ: begin
                d.src_b = rb;
                d.dst_m = ra;
            end
            IC_OPQ: begin
                d.src_a = ra;
                d.src_b = rb;
                d.dst_e = rb;
            end
            IC_CALL: begin
                d.src_b = REG_SP;
                d.dst_e = REG_SP;
            end
            IC_RET: begin
                d.src_a = REG_SP;
                d.src_b = REG_SP;
                d.dst_e = REG_SP;
            end
            IC_PUSHQ: begin
                d.src_a = ra;
                d.src_b = REG_SP;
                d.dst_e = REG_SP;
            end
            IC_POPQ: begin
                d.src_a = REG_SP;
                d.src_b = REG_SP;
                d.dst_e = REG_SP;
                d.dst_m = ra;
            end
            default: begin
                d = '{src_a: REG_NONE, src_b: REG_NONE, dst_e: REG_NONE, dst_m: REG_NONE};
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pipelined_decode_forward.sv
`default_nettype none

// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_in_req  (t_in_req)
// result    out        o_out_valid / i_out_stall o_out_req (t_out_req)
//
// one request per cycle unless the output stalls; via first stage and result register
// register file is read and written on the accepting edge, read data registered
// with the decoded request; forwarding and bubble logic sit before the result register
// synchronous active-low reset clears the register file valid bits and both stage valids
// stall on the result side holds the result and lets one more request into the
// first stage; stall reaches the input only when both stages are full

module pipelined_decode_forward
    import pdf_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_req  i_in_req,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_req      o_out_req
);

    typedef struct packed {
        logic [2:0]            stat;
        t_icode                icode;
        logic [3:0]            ifun;
        t_dec                  dec;
        t_hazard               hz;
        logic [WORD_WIDTH-1:0] valc;
        logic [WORD_WIDTH-1:0] valp;
        logic [WORD_WIDTH-1:0] ex_val;
        logic [WORD_WIDTH-1:0] mload_val;
        logic [WORD_WIDTH-1:0] malu_val;
        logic [WORD_WIDTH-1:0] wload_val;
        logic [WORD_WIDTH-1:0] walu_val;
    } t_s1;

    t_s1                   n_s1;
    t_s1                   r_s1;
    logic                  r_s1_valid;
    logic                  r_out_valid;
    t_out_req              r_out;
    t_out_req              fwd_res;
    logic                  in_accept;
    logic                  out_free;
    logic                  s1_move;
    logic [WORD_WIDTH-1:0] rf_a;
    logic [WORD_WIDTH-1:0] rf_b;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1.stat      = i_in_req.instr_header[18:16];
        n_s1.icode     = i_in_req.instr_header[15:12];
        n_s1.ifun      = i_in_req.instr_header[11:8];
        n_s1.dec       = pick_regs(i_in_req.instr_header[15:12],
                                   i_in_req.instr_header[7:4],
                                   i_in_req.instr_header[3:0]);
        n_s1.hz        = t_hazard'(i_in_req.hazard_tags);
        n_s1.valc      = i_in_req.const_word[WORD_WIDTH-1:0];
        n_s1.valp      = i_in_req.next_pc[WORD_WIDTH-1:0];
        n_s1.ex_val    = i_in_req.exec_value[WORD_WIDTH-1:0];
        n_s1.mload_val = i_in_req.mem_load_value[WORD_WIDTH-1:0];
        n_s1.malu_val  = i_in_req.mem_alu_value[WORD_WIDTH-1:0];
        n_s1.wload_val = i_in_req.wb_load_value[WORD_WIDTH-1:0];
        n_s1.walu_val  = i_in_req.wb_alu_value[WORD_WIDTH-1:0];
    end

    pdf_regfile #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (in_accept),
        .i_rd_addr_a (n_s1.dec.src_a),
        .i_rd_addr_b (n_s1.dec.src_b),
        .i_hz        (n_s1.hz),
        .i_wr_data_e (n_s1.walu_val),
        .i_wr_data_m (n_s1.wload_val),
        .o_rd_a      (rf_a),
        .o_rd_b      (rf_b)
    );

    pdf_forward #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_forward (
        .i_stat      (r_s1.stat),
        .i_icode     (r_s1.icode),
        .i_ifun      (r_s1.ifun),
        .i_dec       (r_s1.dec),
        .i_hz        (r_s1.hz),
        .i_valc      (r_s1.valc),
        .i_valp      (r_s1.valp),
        .i_ex_val    (r_s1.ex_val),
        .i_mload_val (r_s1.mload_val),
        .i_malu_val  (r_s1.malu_val),
        .i_wload_val (r_s1.wload_val),
        .i_walu_val  (r_s1.walu_val),
        .i_rf_a      (rf_a),
        .i_rf_b      (rf_b),
        .o_res       (fwd_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out <= fwd_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid)
        else $error("input stalled with a free stage");

    a_move_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> o_out_valid && (o_out_req == $past(fwd_res)))
        else $error("first stage result lost on its way to the output");

    a_none_source_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_req.source_b == REG_NONE) |-> o_out_req.operand_b == '0)
        else $error("operand b nonzero for source none");

endmodule

`default_nettype wire

### hw/rtl/pdf_rfbank.sv
`default_nettype none

module pdf_rfbank
    import pdf_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rd_en,
    input  wire logic [RF_IDX_W-1:0]   i_rd_addr_a,
    input  wire logic [RF_IDX_W-1:0]   i_rd_addr_b,
    input  wire logic                  i_wr_en,
    input  wire logic [RF_IDX_W-1:0]   i_wr_addr,
    input  wire logic [WORD_WIDTH-1:0] i_wr_data,
    output logic      [WORD_WIDTH-1:0] o_rd_data_a,
    output logic      [WORD_WIDTH-1:0] o_rd_data_b
);

    logic [WORD_WIDTH-1:0] r_mem [RF_DEPTH];

    // read returns the contents from before a write on the same edge
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pdf_regfile.sv
`default_nettype none

module pdf_regfile
    import pdf_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire t_reg_id               i_rd_addr_a,
    input  wire t_reg_id               i_rd_addr_b,
    input  wire t_hazard               i_hz,
    input  wire logic [WORD_WIDTH-1:0] i_wr_data_e,
    input  wire logic [WORD_WIDTH-1:0] i_wr_data_m,
    output logic      [WORD_WIDTH-1:0] o_rd_a,
    output logic      [WORD_WIDTH-1:0] o_rd_b
);

    logic                  we_e;
    logic                  we_m;
    logic [WORD_WIDTH-1:0] bank_e_a;
    logic [WORD_WIDTH-1:0] bank_e_b;
    logic [WORD_WIDTH-1:0] bank_m_a;
    logic [WORD_WIDTH-1:0] bank_m_b;
    logic [RF_DEPTH-1:0]   r_vld;
    logic [RF_DEPTH-1:0]   r_lvt;
    logic [RF_DEPTH-1:0]   n_vld;
    logic [RF_DEPTH-1:0]   n_lvt;
    logic                  r_hit_a;
    logic                  r_hit_b;
    logic                  r_from_m_a;
    logic                  r_from_m_b;

    assign we_e = i_en && (i_hz.w_dste != REG_NONE);
    assign we_m = i_en && (i_hz.w_dstm != REG_NONE);

    pdf_rfbank #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_bank_e (
        .i_clk       (i_clk),
        .i_rd_en     (i_en),
        .i_rd_addr_a (i_rd_addr_a),
        .i_rd_addr_b (i_rd_addr_b),
        .i_wr_en     (we_e),
        .i_wr_addr   (i_hz.w_dste),
        .i_wr_data   (i_wr_data_e),
        .o_rd_data_a (bank_e_a),
        .o_rd_data_b (bank_e_b)
    );

    pdf_rfbank #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_bank_m (
        .i_clk       (i_clk),
        .i_rd_en     (i_en),
        .i_rd_addr_a (i_rd_addr_a),
        .i_rd_addr_b (i_rd_addr_b),
        .i_wr_en     (we_m),
        .i_wr_addr   (i_hz.w_dstm),
        .i_wr_data   (i_wr_data_m),
        .o_rd_data_a (bank_m_a),
        .o_rd_data_b (bank_m_b)
    );

    // live-value table: which bank holds the newest write, load bank wins
    always_comb begin
        n_vld = r_vld;
        n_lvt = r_lvt;
        if (we_e) begin
            n_vld[i_hz.w_dste] = 1'b1;
            n_lvt[i_hz.w_dste] = 1'b0;
        end
        if (we_m) begin
            n_vld[i_hz.w_dstm] = 1'b1;
            n_lvt[i_hz.w_dstm] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_lvt <= '0;
        end else begin
            r_vld <= n_vld;
            r_lvt <= n_lvt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_a    <= 1'b0;
            r_hit_b    <= 1'b0;
            r_from_m_a <= 1'b0;
            r_from_m_b <= 1'b0;
        end else if (i_en) begin
            r_hit_a    <= (i_rd_addr_a != REG_NONE) && r_vld[i_rd_addr_a];
            r_hit_b    <= (i_rd_addr_b != REG_NONE) && r_vld[i_rd_addr_b];
            r_from_m_a <= (i_rd_addr_a != REG_NONE) && r_lvt[i_rd_addr_a];
            r_from_m_b <= (i_rd_addr_b != REG_NONE) && r_lvt[i_rd_addr_b];
        end
    end

    assign o_rd_a = !r_hit_a ? '0 : (r_from_m_a ? bank_m_a : bank_e_a);
    assign o_rd_b = !r_hit_b ? '0 : (r_from_m_b ? bank_m_b : bank_e_b);

    a_load_write_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we_m |=> r_vld[$past(i_hz.w_dstm)] && r_lvt[$past(i_hz.w_dstm)])
        else $error("load writeback not recorded in live-value table");

    a_alu_write_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we_e && !(we_m && (i_hz.w_dstm == i_hz.w_dste))
        |=> r_vld[$past(i_hz.w_dste)] && !r_lvt[$past(i_hz.w_dste)])
        else $error("alu writeback not recorded in live-value table");

    a_none_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (i_rd_addr_a == REG_NONE) |=> o_rd_a == '0)
        else $error("read of register none is not zero");

endmodule

`default_nettype wire

### hw/rtl/pdf_forward.sv
`default_nettype none

module pdf_forward
    import pdf_pkg::*;
#(
    parameter int WORD_WIDTH = 64
) (
    input  wire logic [2:0]            i_stat,
    input  wire t_icode                i_icode,
    input  wire logic [3:0]            i_ifun,
    input  wire t_dec                  i_dec,
    input  wire t_hazard               i_hz,
    input  wire logic [WORD_WIDTH-1:0] i_valc,
    input  wire logic [WORD_WIDTH-1:0] i_valp,
    input  wire logic [WORD_WIDTH-1:0] i_ex_val,
    input  wire logic [WORD_WIDTH-1:0] i_mload_val,
    input  wire logic [WORD_WIDTH-1:0] i_malu_val,
    input  wire logic [WORD_WIDTH-1:0] i_wload_val,
    input  wire logic [WORD_WIDTH-1:0] i_walu_val,
    input  wire logic [WORD_WIDTH-1:0] i_rf_a,
    input  wire logic [WORD_WIDTH-1:0] i_rf_b,
    output t_out_req                   o_res
);

    logic [WORD_WIDTH-1:0] op_a;
    logic [WORD_WIDTH-1:0] op_b;
    logic                  bubble;

    always_comb begin
        if ((i_icode == IC_CALL) || (i_icode == IC_JXX)) begin
            op_a = i_valp;
        end else if (i_dec.src_a == REG_NONE) begin
            op_a = '0;
        end else if (i_dec.src_a == i_hz.e_dste) begin
            op_a = i_ex_val;
        end else if (i_dec.src_a == i_hz.m_dstm) begin
            op_a = i_mload_val;
        end else if (i_dec.src_a == i_hz.m_dste) begin
            op_a = i_malu_val;
        end else if (i_dec.src_a == i_hz.w_dstm) begin
            op_a = i_wload_val;
        end else if (i_dec.src_a == i_hz.w_dste) begin
            op_a = i_walu_val;
        end else begin
            op_a = i_rf_a;
        end
    end

    always_comb begin
        if (i_dec.src_b == REG_NONE) begin
            op_b = '0;
        end else if (i_dec.src_b == i_hz.e_dste) begin
            op_b = i_ex_val;
        end else if (i_dec.src_b == i_hz.m_dstm) begin
            op_b = i_mload_val;
        end else if (i_dec.src_b == i_hz.m_dste) begin
            op_b = i_malu_val;
        end else if (i_dec.src_b == i_hz.w_dstm) begin
            op_b = i_wload_val;
        end else if (i_dec.src_b == i_hz.w_dste) begin
            op_b = i_walu_val;
        end else begin
            op_b = i_rf_b;
        end
    end

    // mispredicted branch or load-use
    assign bubble = ((i_hz.e_icode == IC_JXX) && !i_hz.e_cnd)
                 || (((i_hz.e_icode == IC_MRMOVQ) || (i_hz.e_icode == IC_POPQ))
                     && ((i_hz.e_dstm == i_dec.src_a) || (i_hz.e_dstm == i_dec.src_b)));

    always_comb begin
        o_res.out_stat      = i_stat;
        o_res.out_icode     = i_icode;
        o_res.out_ifun      = i_ifun;
        o_res.out_valc      = WORD_FIELD_W'(i_valc);
        o_res.operand_a     = WORD_FIELD_W'(op_a);
        o_res.operand_b     = WORD_FIELD_W'(op_b);
        o_res.dest_e        = i_dec.dst_e;
        o_res.dest_m        = i_dec.dst_m;
        o_res.source_a      = i_dec.src_a;
        o_res.source_b      = i_dec.src_b;
        o_res.insert_bubble = bubble;
    end

endmodule

`default_nettype wire

### tb/pipelined_decode_forward_tb.sv
module pipelined_decode_forward_tb;
    import pdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WORD_W    = 64;
    localparam logic [63:0] WORD_MASK = {64{1'b1}} >> (64 - WORD_W);
    localparam int          N_RANDOM  = 1900;
    localparam int          MAX_PRINT = 50;

    localparam t_icode IC_HALT = 4'd0;

    localparam logic [63:0] V_VALC  = 64'h0123_4567_89ab_cdef;
    localparam logic [63:0] V_PC    = 64'h0000_0000_0000_1000;
    localparam logic [63:0] V_EXEC  = 64'he0e0_e0e0_0000_0001;
    localparam logic [63:0] V_MLOAD = 64'h4d4d_4d4d_0000_0002;
    localparam logic [63:0] V_MALU  = 64'h3a3a_3a3a_0000_0003;
    localparam logic [63:0] V_WLOAD = 64'h7b7b_7b7b_0000_0004;
    localparam logic [63:0] V_WALU  = 64'h5c5c_5c5c_0000_0005;

    localparam t_hazard HZ_QUIET =
        {REG_NONE, REG_NONE, REG_NONE, REG_NONE, REG_NONE, IC_HALT, REG_NONE, 1'b0};

    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_req want;
    } t_dir_row;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_in_req  i_in_req    = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_req o_out_req;

    logic [63:0] shadow_regs [0:14];
    t_out_req    expected_decodes [$];
    t_dir_row    dir_rows [$];
    t_out_req    want_req;
    int          error_count = 0;
    bit          src_burst   = 1'b0;
    bit          sink_burst  = 1'b0;

    pipelined_decode_forward #(
        .WORD_WIDTH(WORD_W)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_req(i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_req(o_out_req)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] operand_for(input t_reg_id src, input t_hazard hz,
                                                input t_in_req r);
        if (src == REG_NONE) return '0;
        if (src == hz.e_dste) return r.exec_value & WORD_MASK;
        if (src == hz.m_dstm) return r.mem_load_value & WORD_MASK;
        if (src == hz.m_dste) return r.mem_alu_value & WORD_MASK;
        if (src == hz.w_dstm) return r.wb_load_value & WORD_MASK;
        if (src == hz.w_dste) return r.wb_alu_value & WORD_MASK;
        return shadow_regs[src];
    endfunction

    function automatic t_out_req decode_and_forward(input t_in_req r);
        t_hazard  hz;
        t_icode   ic;
        t_reg_id  ra;
        t_reg_id  rb;
        t_out_req o;
        hz = t_hazard'(r.hazard_tags);
        ic = r.instr_header[15:12];
        ra = r.instr_header[7:4];
        rb = r.instr_header[3:0];
        o = '0;
        o.out_stat  = r.instr_header[18:16];
        o.out_icode = ic;
        o.out_ifun  = r.instr_header[11:8];
        o.out_valc  = r.const_word & WORD_MASK;
        case (ic)
            IC_RRMOVQ, IC_RMMOVQ, IC_OPQ, IC_PUSHQ: o.source_a = ra;
            IC_POPQ, IC_RET: o.source_a = REG_SP;
            default: o.source_a = REG_NONE;
        endcase
        case (ic)
            IC_OPQ, IC_RMMOVQ, IC_MRMOVQ: o.source_b = rb;
            IC_PUSHQ, IC_POPQ, IC_CALL, IC_RET: o.source_b = REG_SP;
            default: o.source_b = REG_NONE;
        endcase
        case (ic)
            IC_RRMOVQ, IC_IRMOVQ, IC_OPQ: o.dest_e = rb;
            IC_PUSHQ, IC_POPQ, IC_CALL, IC_RET: o.dest_e = REG_SP;
            default: o.dest_e = REG_NONE;
        endcase
        o.dest_m = (ic == IC_MRMOVQ || ic == IC_POPQ) ? ra : REG_NONE;
        if (ic == IC_CALL || ic == IC_JXX) begin
            o.operand_a = r.next_pc & WORD_MASK;
        end else begin
            o.operand_a = operand_for(o.source_a, hz, r);
        end
        o.operand_b = operand_for(o.source_b, hz, r);
        o.insert_bubble = (hz.e_icode == IC_JXX && !hz.e_cnd) ||
                          ((hz.e_icode == IC_MRMOVQ || hz.e_icode == IC_POPQ) &&
                           (hz.e_dstm == o.source_a || hz.e_dstm == o.source_b));
        // register file written after the reads, load value last
        if (hz.w_dste != REG_NONE) shadow_regs[hz.w_dste] = r.wb_alu_value & WORD_MASK;
        if (hz.w_dstm != REG_NONE) shadow_regs[hz.w_dstm] = r.wb_load_value & WORD_MASK;
        return o;
    endfunction

    function automatic t_in_req mk_req(input logic [2:0] st, input t_icode ic,
                                       input logic [3:0] fn, input t_reg_id ra,
                                       input t_reg_id rb, input t_hazard h);
        t_in_req r;
        r.instr_header   = {st, ic, fn, ra, rb};
        r.const_word     = V_VALC;
        r.next_pc        = V_PC;
        r.hazard_tags    = h;
        r.exec_value     = V_EXEC;
        r.mem_load_value = V_MLOAD;
        r.mem_alu_value  = V_MALU;
        r.wb_load_value  = V_WLOAD;
        r.wb_alu_value   = V_WALU;
        return r;
    endfunction

    function automatic t_out_req mk_out(input logic [2:0] st, input t_icode ic,
                                        input logic [3:0] fn, input logic [63:0] valc,
                                        input logic [63:0] a, input logic [63:0] b,
                                        input t_reg_id de, input t_reg_id dm,
                                        input t_reg_id sa, input t_reg_id sb,
                                        input logic bub);
        t_out_req o;
        o.out_stat      = st;
        o.out_icode     = ic;
        o.out_ifun      = fn;
        o.out_valc      = valc;
        o.operand_a     = a;
        o.operand_b     = b;
        o.dest_e        = de;
        o.dest_m        = dm;
        o.source_a      = sa;
        o.source_b      = sb;
        o.insert_bubble = bub;
        return o;
    endfunction

    task automatic add_row(input t_in_req r, input bit typed, input t_out_req w);
        t_dir_row row;
        row.req   = r;
        row.typed = typed;
        row.want  = w;
        dir_rows.push_back(row);
    endtask

    task automatic build_directed();
        t_hazard     h;
        t_in_req     r;
        logic [63:0] fwd_vals [0:4];
        fwd_vals = '{V_EXEC, V_MLOAD, V_MALU, V_WLOAD, V_WALU};
        add_row(mk_req(3'd0, IC_OPQ, 4'd0, 4'd0, 4'd1, HZ_QUIET), 1'b1,
                mk_out(3'd0, IC_OPQ, 4'd0, V_VALC, '0, '0, 4'd1, REG_NONE, 4'd0, 4'd1, 1'b0));
        r = '1;
        add_row(r, 1'b1, mk_out(3'd7, 4'd15, 4'd15, '1, '0, '0,
                                REG_NONE, REG_NONE, REG_NONE, REG_NONE, 1'b0));
        r = '0;
        add_row(r, 1'b1, mk_out(3'd0, IC_HALT, 4'd0, '0, '0, '0,
                                REG_NONE, REG_NONE, REG_NONE, REG_NONE, 1'b0));
        // both writeback ports on one register, load value wins
        h = HZ_QUIET;
        h.w_dste = 4'd5;
        h.w_dstm = 4'd5;
        add_row(mk_req(3'd1, IC_HALT, 4'd0, 4'd0, 4'd0, h), 1'b1,
                mk_out(3'd1, IC_HALT, 4'd0, V_VALC, '0, '0,
                       REG_NONE, REG_NONE, REG_NONE, REG_NONE, 1'b0));
        h = HZ_QUIET;
        h.w_dste = REG_SP;
        add_row(mk_req(3'd1, IC_HALT, 4'd0, 4'd0, 4'd0, h), 1'b1,
                mk_out(3'd1, IC_HALT, 4'd0, V_VALC, '0, '0,
                       REG_NONE, REG_NONE, REG_NONE, REG_NONE, 1'b0));
        add_row(mk_req(3'd2, IC_RRMOVQ, 4'd0, 4'd5, 4'd6, HZ_QUIET), 1'b1,
                mk_out(3'd2, IC_RRMOVQ, 4'd0, V_VALC, V_WLOAD, '0,
                       4'd6, REG_NONE, 4'd5, REG_NONE, 1'b0));
        add_row(mk_req(3'd0, IC_CALL, 4'd0, 4'd9, 4'd9, HZ_QUIET), 1'b1,
                mk_out(3'd0, IC_CALL, 4'd0, V_VALC, V_PC, V_WALU,
                       REG_SP, REG_NONE, REG_NONE, REG_SP, 1'b0));
        // mispredicted jump, then a taken one
        h = HZ_QUIET;
        h.e_icode = IC_JXX;
        r = mk_req(3'd0, IC_JXX, 4'd3, REG_NONE, REG_NONE, h);
        r.next_pc = '1;
        add_row(r, 1'b1, mk_out(3'd0, IC_JXX, 4'd3, V_VALC, '1, '0,
                                REG_NONE, REG_NONE, REG_NONE, REG_NONE, 1'b1));
        h.e_cnd = 1'b1;
        add_row(mk_req(3'd0, IC_JXX, 4'd1, REG_NONE, REG_NONE, h), 1'b1,
                mk_out(3'd0, IC_JXX, 4'd1, V_VALC, V_PC, '0,
                       REG_NONE, REG_NONE, REG_NONE, REG_NONE, 1'b0));
        // forwarding priority, newest stage dropped one at a time
        for (int k = 0; k < 5; k++) begin
            h = HZ_QUIET;
            if (k <= 0) h.e_dste = 4'd3;
            if (k <= 1) h.m_dstm = 4'd3;
            if (k <= 2) h.m_dste = 4'd3;
            if (k <= 3) h.w_dstm = 4'd3;
            h.w_dste = 4'd3;
            add_row(mk_req(3'd0, IC_OPQ, 4'd2, 4'd3, 4'd3, h), 1'b1,
                    mk_out(3'd0, IC_OPQ, 4'd2, V_VALC, fwd_vals[k], fwd_vals[k],
                           4'd3, REG_NONE, 4'd3, 4'd3, 1'b0));
        end
        add_row(mk_req(3'd0, IC_IRMOVQ, 4'd0, REG_NONE, 4'd7, HZ_QUIET), 1'b1,
                mk_out(3'd0, IC_IRMOVQ, 4'd0, V_VALC, '0, '0,
                       4'd7, REG_NONE, REG_NONE, REG_NONE, 1'b0));
        // none sources never pick up a stage writing none
        h = HZ_QUIET;
        h.e_icode = IC_OPQ;
        add_row(mk_req(3'd0, IC_OPQ, 4'd0, REG_NONE, REG_NONE, h), 1'b1,
                mk_out(3'd0, IC_OPQ, 4'd0, V_VALC, '0, '0,
                       REG_NONE, REG_NONE, REG_NONE, REG_NONE, 1'b0));
        // load-use hazards, then the remaining instruction kinds without hazards
        h = HZ_QUIET;
        h.e_icode = IC_MRMOVQ;
        h.e_dstm  = 4'd2;
        add_row(mk_req(3'd0, IC_OPQ, 4'd1, 4'd2, 4'd9, h), 1'b0, '0);
        h.e_icode = IC_POPQ;
        h.e_dstm  = REG_SP;
        add_row(mk_req(3'd0, IC_PUSHQ, 4'd0, 4'd1, REG_NONE, h), 1'b0, '0);
        h.e_icode = IC_MRMOVQ;
        h.e_dstm  = REG_NONE;
        add_row(mk_req(3'd0, IC_IRMOVQ, 4'd0, REG_NONE, 4'd8, h), 1'b1,
                mk_out(3'd0, IC_IRMOVQ, 4'd0, V_VALC, '0, '0,
                       4'd8, REG_NONE, REG_NONE, REG_NONE, 1'b1));
        add_row(mk_req(3'd0, IC_RMMOVQ, 4'd0, 4'd5, 4'd4, HZ_QUIET), 1'b0, '0);
        add_row(mk_req(3'd0, IC_MRMOVQ, 4'd0, 4'd10, 4'd5, HZ_QUIET), 1'b0, '0);
        add_row(mk_req(3'd0, IC_RET, 4'd0, REG_NONE, REG_NONE, HZ_QUIET), 1'b0, '0);
        add_row(mk_req(3'd0, IC_PUSHQ, 4'd0, 4'd14, REG_NONE, HZ_QUIET), 1'b0, '0);
        add_row(mk_req(3'd0, IC_POPQ, 4'd0, 4'd14, REG_NONE, HZ_QUIET), 1'b0, '0);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_reg_id near_id(input t_reg_id ra, input t_reg_id rb);
        case ($urandom_range(0, 5))
            0: return ra;
            1: return rb;
            2: return REG_SP;
            3: return REG_NONE;
            default: return t_reg_id'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic t_in_req rand_request();
        t_in_req r;
        t_hazard h;
        t_icode  ic;
        t_reg_id ra;
        t_reg_id rb;
        ic = ($urandom_range(0, 9) < 8) ? t_icode'($urandom_range(IC_RRMOVQ, IC_POPQ))
                                         : t_icode'($urandom_range(0, 15));
        ra = ($urandom_range(0, 7) == 0) ? REG_NONE : t_reg_id'($urandom_range(0, 14));
        rb = ($urandom_range(0, 7) == 0) ? REG_NONE : t_reg_id'($urandom_range(0, 14));
        h.e_dste = near_id(ra, rb);
        h.m_dstm = near_id(ra, rb);
        h.m_dste = near_id(ra, rb);
        h.w_dstm = near_id(ra, rb);
        h.w_dste = near_id(ra, rb);
        case ($urandom_range(0, 3))
            0: h.e_icode = IC_JXX;
            1: h.e_icode = IC_MRMOVQ;
            2: h.e_icode = IC_POPQ;
            default: h.e_icode = t_icode'($urandom_range(0, 15));
        endcase
        h.e_dstm = near_id(ra, rb);
        h.e_cnd  = 1'($urandom_range(0, 1));
        r.instr_header   = {3'($urandom_range(0, 7)), ic, 4'($urandom_range(0, 15)), ra, rb};
        r.const_word     = rand_word();
        r.next_pc        = rand_word();
        r.hazard_tags    = h;
        r.exec_value     = rand_word();
        r.mem_load_value = rand_word();
        r.mem_alu_value  = rand_word();
        r.wb_load_value  = rand_word();
        r.wb_alu_value   = rand_word();
        return r;
    endfunction

    task automatic send_request(input t_in_req r, input bit typed, input t_out_req w);
        int       gap;
        t_out_req predicted;
        if ($urandom_range(0, 49) == 0) src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = decode_and_forward(r);
        expected_decodes.push_back(typed ? w : predicted);
    endtask

    task automatic flag_error(input string msg);
        if (error_count < MAX_PRINT) $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic cmp(input string name, input logic [63:0] got, input logic [63:0] want);
        if (got !== want) flag_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_decodes.size() == 0) begin
                flag_error("request out with nothing pending");
            end else begin
                want_req = expected_decodes.pop_front();
                cmp("out_stat", o_out_req.out_stat, want_req.out_stat);
                cmp("out_icode", o_out_req.out_icode, want_req.out_icode);
                cmp("out_ifun", o_out_req.out_ifun, want_req.out_ifun);
                cmp("out_valc", o_out_req.out_valc, want_req.out_valc);
                cmp("operand_a", o_out_req.operand_a, want_req.operand_a);
                cmp("operand_b", o_out_req.operand_b, want_req.operand_b);
                cmp("dest_e", o_out_req.dest_e, want_req.dest_e);
                cmp("dest_m", o_out_req.dest_m, want_req.dest_m);
                cmp("source_a", o_out_req.source_a, want_req.source_a);
                cmp("source_b", o_out_req.source_b, want_req.source_b);
                cmp("insert_bubble", o_out_req.insert_bubble, want_req.insert_bubble);
            end
        end
    end

    initial begin
        int n;
        forever begin
            if ($urandom_range(0, 49) == 0) sink_burst = !sink_burst;
            n = sink_burst ? 0 : $urandom_range(0, 19);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        #5000000;
        $display("** pipelined_decode_forward: FAILED **");
        $finish;
    end

    initial begin
        for (int k = 0; k < 15; k++) shadow_regs[k] = '0;
        build_directed();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[k]) send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
        repeat (N_RANDOM) send_request(rand_request(), 1'b0, '0);
        i_in_valid <= 1'b0;
        while (expected_decodes.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** pipelined_decode_forward: PASSED **");
        end else begin
            $display("** pipelined_decode_forward: FAILED **");
        end
        $finish;
    end

endmodule
